[rtl/nmea_gga_position_parser_core_assert.svh]
// Assertion macros used by the GGA parser port-level checker.
`ifndef NMEA_GGA_POSITION_PARSER_CORE_ASSERT_SVH
`define NMEA_GGA_POSITION_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NGGP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NGGP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/nggp_pkg.sv]
// Types, character codes and helper tables for the GGA position parser.
package nggp_pkg;

   localparam int unsigned VALUE_W   = 30;
   localparam int unsigned TOKEN_W   = 7;
   localparam int unsigned POW_W     = 20;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd999999999;
   localparam logic [TOKEN_W-1:0] TOKEN_MAX = 7'd127;

   // Token indexes within a line (header is token 0)
   localparam logic [TOKEN_W-1:0] TOKEN_LAT = 7'd2;
   localparam logic [TOKEN_W-1:0] TOKEN_LON = 7'd4;
   localparam logic [TOKEN_W-1:0] TOKEN_FIX = 7'd6;

   // ASCII codes
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam int unsigned HEADER_LEN = 6;

   // Summary of one finished line
   typedef struct packed {
      logic               done;
      logic               gga;
      logic               fix;
      logic [VALUE_W-1:0] latitude;
      logic [VALUE_W-1:0] longitude;
   } line_result_type;

   // Expected header "$GPGGA", one character per position
   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = CHAR_DOLLAR;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h47;
         3'd5:    ch = 8'h41;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   // Powers of ten for the fraction zero fill
   function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
      logic [POW_W-1:0] p;
      unique case (k)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

endpackage

[rtl/nmea_gga_position_parser_core.sv]
// Top level of the GGA position parser: input register, line parser, result register.
//
//   channel | direction | ports                                   | item
//   req     | in        | req_valid, req_stall, req_rx_byte       | one serial byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_* fields      | one line summary
//
// Each byte is registered in the input register, then parsed: one byte per cycle while req_stall
// is low; the result item of a newline is then registered in the result register.
// Only newline bytes produce an item; all other bytes just update the line state.
// Reset clears the line state, the held position and the result valid flag.
// A result waiting under rsp_stall blocks only a following newline byte; other
// bytes keep flowing, so req_stall rises only when a newline meets a full result.
module nmea_gga_position_parser_core #(
   parameter int unsigned BUFFER_BYTES    = 100,
   parameter int unsigned FRACTION_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sentence_is_gga,
   output logic        rsp_fix_ok,
   output logic        rsp_position_updated,
   output logic [29:0] rsp_latitude_micro,
   output logic [29:0] rsp_longitude_micro
);

   localparam int unsigned VW = nggp_pkg::VALUE_W;

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_advance;
   logic                      in_blocked;
   nggp_pkg::line_result_type line_result;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      gga_ff;
   logic                      fix_ff;
   logic [VW-1:0]             held_latitude_ff, held_latitude_in;
   logic [VW-1:0]             held_longitude_ff, held_longitude_in;

   // A newline item cannot enter while the previous result is still stalled
   assign in_blocked = (in_byte_ff == nggp_pkg::CHAR_NEWLINE) && rsp_valid_ff && rsp_stall;
   assign in_advance = in_valid_ff && !in_blocked;
   assign req_stall  = in_valid_ff && in_blocked;

   // Input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) in_valid_in = 1'b1;
      else if (in_advance)         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_byte_ff <= req_rx_byte;
   end

   // Line parser
   nggp_field_parser #(
      .BUFFER_BYTES   (BUFFER_BYTES),
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_field_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (in_advance),
      .rx_byte    (in_byte_ff),
      .line_result(line_result)
   );

   // Result register and held position
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      held_latitude_in  = held_latitude_ff;
      held_longitude_in = held_longitude_ff;
      if (line_result.done) rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
      if (line_result.done && line_result.fix) begin
         held_latitude_in  = line_result.latitude;
         held_longitude_in = line_result.longitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         held_latitude_ff  <= '0;
         held_longitude_ff <= '0;
      end else begin
         rsp_valid_ff      <= rsp_valid_in;
         held_latitude_ff  <= held_latitude_in;
         held_longitude_ff <= held_longitude_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_result.done) begin
         gga_ff <= line_result.gga;
         fix_ff <= line_result.fix;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sentence_is_gga  = gga_ff;
   assign rsp_fix_ok           = fix_ff;
   assign rsp_position_updated = fix_ff;
   assign rsp_latitude_micro   = held_latitude_ff;
   assign rsp_longitude_micro  = held_longitude_ff;

endmodule

[rtl/nggp_field_parser.sv]
// Line state and field accumulation: one byte per step, line summary on newline.
module nggp_field_parser #(
   parameter int unsigned BUFFER_BYTES    = 100,
   parameter int unsigned FRACTION_DIGITS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output nggp_pkg::line_result_type line_result
);

   localparam int unsigned LP_W = $clog2(BUFFER_BYTES);
   localparam int unsigned FC_W = $clog2(FRACTION_DIGITS + 1);
   localparam int unsigned VW   = nggp_pkg::VALUE_W;
   localparam int unsigned TW   = nggp_pkg::TOKEN_W;

   // Line state
   logic [LP_W-1:0] line_position_ff,   line_position_in;
   logic            header_matches_ff,  header_matches_in;
   logic [TW-1:0]   token_number_ff,    token_number_in;
   logic            inside_token_ff,    inside_token_in;
   logic            number_stopped_ff,  number_stopped_in;
   logic            point_seen_ff,      point_seen_in;
   logic [FC_W-1:0] fraction_count_ff,  fraction_count_in;
   logic [VW-1:0]   latitude_accum_ff,  latitude_accum_in;
   logic [VW-1:0]   longitude_accum_ff, longitude_accum_in;
   logic            fix_nonzero_ff,     fix_nonzero_in;
   logic            fix_negative_ff,    fix_negative_in;
   logic            text_ended_ff,      text_ended_in;

   // acc * 10 + digit, saturating
   function automatic logic [VW-1:0] sat_times_ten(input logic [VW-1:0] acc,
                                                   input logic [3:0] d);
      logic [VW+3:0] v;
      v = (VW+4)'(acc) * (VW+4)'(10) + (VW+4)'(d);
      return (v > (VW+4)'(nggp_pkg::VALUE_MAX)) ? nggp_pkg::VALUE_MAX : v[VW-1:0];
   endfunction

   // acc * 10^k, saturating
   function automatic logic [VW-1:0] sat_pad(input logic [VW-1:0] acc,
                                             input logic [2:0] k);
      logic [VW+nggp_pkg::POW_W-1:0] p;
      p = (VW+nggp_pkg::POW_W)'(acc) * (VW+nggp_pkg::POW_W)'(nggp_pkg::pow10(k));
      return (p > (VW+nggp_pkg::POW_W)'(nggp_pkg::VALUE_MAX)) ?
             nggp_pkg::VALUE_MAX : p[VW-1:0];
   endfunction

   // Next-state logic for one byte
   always_comb begin
      logic          kept;
      logic          text_taken;
      logic          first;
      logic          is_digit;
      logic [3:0]    digit;
      logic          acc_token;
      logic          acc_is_lon;
      logic          acc_wr;
      logic [VW-1:0] acc_sel;
      logic [VW-1:0] acc_new;
      logic          close_now;
      logic          is_newline;

      line_position_in   = line_position_ff;
      header_matches_in  = header_matches_ff;
      token_number_in    = token_number_ff;
      inside_token_in    = inside_token_ff;
      number_stopped_in  = number_stopped_ff;
      point_seen_in      = point_seen_ff;
      fraction_count_in  = fraction_count_ff;
      latitude_accum_in  = latitude_accum_ff;
      longitude_accum_in = longitude_accum_ff;
      fix_nonzero_in     = fix_nonzero_ff;
      fix_negative_in    = fix_negative_ff;
      text_ended_in      = text_ended_ff;

      is_newline = (rx_byte == nggp_pkg::CHAR_NEWLINE);

      // '$' restarts the line
      if (rx_byte == nggp_pkg::CHAR_DOLLAR) begin
         line_position_in   = '0;
         header_matches_in  = 1'b0;
         token_number_in    = '0;
         inside_token_in    = 1'b0;
         number_stopped_in  = 1'b0;
         point_seen_in      = 1'b0;
         fraction_count_in  = '0;
         latitude_accum_in  = '0;
         longitude_accum_in = '0;
         fix_nonzero_in     = 1'b0;
         fix_negative_in    = 1'b0;
         text_ended_in      = 1'b0;
      end

      is_digit   = (rx_byte >= nggp_pkg::CHAR_ZERO) && (rx_byte <= nggp_pkg::CHAR_NINE);
      digit      = is_digit ? 4'(rx_byte - nggp_pkg::CHAR_ZERO) : 4'd0;
      first      = !inside_token_in;
      acc_is_lon = (token_number_in == nggp_pkg::TOKEN_LON);
      acc_token  = (token_number_in == nggp_pkg::TOKEN_LAT) || acc_is_lon;
      acc_sel    = acc_is_lon ? longitude_accum_in : latitude_accum_in;
      acc_new    = acc_sel;
      acc_wr     = 1'b0;

      kept       = (line_position_in < LP_W'(BUFFER_BYTES - 1));
      text_taken = kept && !text_ended_in;

      if (kept) begin
         // header compare over the first six bytes
         if (line_position_in == '0) begin
            header_matches_in = (rx_byte == nggp_pkg::header_char(3'd0));
         end else if (line_position_in < LP_W'(nggp_pkg::HEADER_LEN)) begin
            header_matches_in = header_matches_in &&
                                (rx_byte == nggp_pkg::header_char(line_position_in[2:0]));
         end

         // tokenizer
         if (!text_ended_in) begin
            if (rx_byte == nggp_pkg::CHAR_NUL) begin
               text_ended_in = 1'b1;
            end else if (rx_byte != nggp_pkg::CHAR_COMMA) begin
               if (first) begin
                  inside_token_in   = 1'b1;
                  number_stopped_in = 1'b0;
                  point_seen_in     = 1'b0;
                  fraction_count_in = '0;
               end
               if (!number_stopped_in) begin
                  if (acc_token) begin
                     if (is_digit) begin
                        if (!point_seen_in) begin
                           acc_new = sat_times_ten(acc_sel, digit);
                           acc_wr  = 1'b1;
                        end else if (fraction_count_in < FC_W'(FRACTION_DIGITS)) begin
                           acc_new           = sat_times_ten(acc_sel, digit);
                           acc_wr            = 1'b1;
                           fraction_count_in = fraction_count_in + FC_W'(1);
                        end
                     end else if (rx_byte == nggp_pkg::CHAR_DOT && !point_seen_in) begin
                        point_seen_in = 1'b1;
                     end else begin
                        number_stopped_in = 1'b1;
                     end
                  end else if (token_number_in == nggp_pkg::TOKEN_FIX) begin
                     if (is_digit) begin
                        if (digit != 4'd0) fix_nonzero_in = 1'b1;
                     end else if (first && rx_byte == nggp_pkg::CHAR_MINUS) begin
                        fix_negative_in = 1'b1;
                     end else if (!(first && rx_byte == nggp_pkg::CHAR_PLUS)) begin
                        number_stopped_in = 1'b1;
                     end
                  end
               end
            end
         end
         line_position_in = line_position_in + LP_W'(1);
      end

      // token close on comma or newline; zero-fill missing fraction digits
      close_now = inside_token_in &&
                  (is_newline || (text_taken && rx_byte == nggp_pkg::CHAR_COMMA));
      if (close_now) begin
         if (acc_token) begin
            acc_new = sat_pad(acc_sel, 3'(FRACTION_DIGITS) - 3'(fraction_count_in));
            acc_wr  = 1'b1;
         end
         if (token_number_in != nggp_pkg::TOKEN_MAX) begin
            token_number_in = token_number_in + TW'(1);
         end
         inside_token_in = 1'b0;
      end

      if (acc_wr) begin
         if (acc_is_lon) longitude_accum_in = acc_new;
         else            latitude_accum_in  = acc_new;
      end

      // line summary
      line_result.done      = step && is_newline;
      line_result.gga       = header_matches_in &&
                              (line_position_in >= LP_W'(nggp_pkg::HEADER_LEN));
      line_result.fix       = line_result.gga && fix_nonzero_in && !fix_negative_in;
      line_result.latitude  = latitude_accum_in;
      line_result.longitude = longitude_accum_in;

      // newline ends the line
      if (is_newline) begin
         line_position_in   = '0;
         header_matches_in  = 1'b0;
         token_number_in    = '0;
         inside_token_in    = 1'b0;
         number_stopped_in  = 1'b0;
         point_seen_in      = 1'b0;
         fraction_count_in  = '0;
         latitude_accum_in  = '0;
         longitude_accum_in = '0;
         fix_nonzero_in     = 1'b0;
         fix_negative_in    = 1'b0;
         text_ended_in      = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_position_ff   <= '0;
         header_matches_ff  <= 1'b0;
         token_number_ff    <= '0;
         inside_token_ff    <= 1'b0;
         number_stopped_ff  <= 1'b0;
         point_seen_ff      <= 1'b0;
         fraction_count_ff  <= '0;
         latitude_accum_ff  <= '0;
         longitude_accum_ff <= '0;
         fix_nonzero_ff     <= 1'b0;
         fix_negative_ff    <= 1'b0;
         text_ended_ff      <= 1'b0;
      end else if (step) begin
         line_position_ff   <= line_position_in;
         header_matches_ff  <= header_matches_in;
         token_number_ff    <= token_number_in;
         inside_token_ff    <= inside_token_in;
         number_stopped_ff  <= number_stopped_in;
         point_seen_ff      <= point_seen_in;
         fraction_count_ff  <= fraction_count_in;
         latitude_accum_ff  <= latitude_accum_in;
         longitude_accum_ff <= longitude_accum_in;
         fix_nonzero_ff     <= fix_nonzero_in;
         fix_negative_ff    <= fix_negative_in;
         text_ended_ff      <= text_ended_in;
      end
   end

endmodule

[rtl/nggp_checker.sv]
// Port-level checker for the GGA position parser, bound to the top level.
`include "nmea_gga_position_parser_core_assert.svh"

module nggp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_sentence_is_gga,
   input logic        rsp_fix_ok,
   input logic        rsp_position_updated,
   input logic [29:0] rsp_latitude_micro,
   input logic [29:0] rsp_longitude_micro
);

   // a fix is only reported for a GGA line
   `NGGP_ASSERT_IMPLY(a_fix_needs_gga, clock, reset, rsp_valid,
      !rsp_fix_ok || rsp_sentence_is_gga, "fix_ok without GGA header")

   // position_updated always equals fix_ok on a valid result
   `NGGP_ASSERT_IMPLY(a_update_matches_fix, clock, reset, rsp_valid,
      rsp_position_updated == rsp_fix_ok, "position_updated differs from fix_ok")

   // input back-pressure only comes from a stalled result
   `NGGP_ASSERT_IMPLY(a_stall_from_rsp, clock, reset, req_valid && req_stall,
      rsp_valid && rsp_stall, "req_stall without a stalled result")

   // a stalled result item holds its position
   `NGGP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_latitude_micro) && $stable(rsp_longitude_micro),
      "stalled result changed")

endmodule

bind nmea_gga_position_parser_core nggp_checker u_nggp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_sentence_is_gga (rsp_sentence_is_gga),
   .rsp_fix_ok          (rsp_fix_ok),
   .rsp_position_updated(rsp_position_updated),
   .rsp_latitude_micro  (rsp_latitude_micro),
   .rsp_longitude_micro (rsp_longitude_micro)
);

[tb/sv/nmea_gga_position_parser_core_checker.sv]
`timescale 1ns / 100ps
// Checker for the GGA parser: tracks each accepted byte, predicts line summaries, compares them.
module nmea_gga_position_parser_core_checker #(
   parameter int unsigned BUFFER_BYTES    = 100,
   parameter int unsigned FRACTION_DIGITS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_sentence_is_gga,
   input  logic              rsp_fix_ok,
   input  logic              rsp_position_updated,
   input  logic [29:0]       rsp_latitude_micro,
   input  logic [29:0]       rsp_longitude_micro,
   output int unsigned       mismatch_count,
   output int unsigned       pending_lines,
   output int unsigned       lines_checked,
   output int unsigned       gga_lines,
   output int unsigned       update_lines
);

   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned HDR_LEN      = nggp_pkg::HEADER_LEN;
   localparam int unsigned VW           = nggp_pkg::VALUE_W;
   localparam int unsigned TW           = nggp_pkg::TOKEN_W;
   localparam logic [8*HDR_LEN-1:0] GGA_TAG = "$GPGGA";

   // one predicted line summary
   typedef struct packed {
      logic          gga;
      logic          fix;
      logic          upd;
      logic [VW-1:0] lat;
      logic [VW-1:0] lon;
   } line_summary_type;

   line_summary_type summary_q[$];

   // line parser state
   int unsigned   line_pos;
   logic          hdr_ok;
   logic [TW-1:0] field_idx;
   logic          in_field;
   logic          num_stopped;
   logic          point_seen;
   logic [2:0]    frac_cnt;
   logic [VW-1:0] lat_acc;
   logic [VW-1:0] lon_acc;
   logic          fix_nz;
   logic          fix_neg;
   logic          text_ended;
   logic [VW-1:0] held_lat;
   logic [VW-1:0] held_lon;

   // acc * 10 + digit, clamped to the largest value
   function automatic logic [VW-1:0] times_ten_plus(input logic [VW-1:0] acc,
                                                    input logic [3:0] digit);
      logic [35:0] v;
      v = 36'(acc) * 36'd10 + 36'(digit);
      return (v > 36'(nggp_pkg::VALUE_MAX)) ? nggp_pkg::VALUE_MAX : v[VW-1:0];
   endfunction

   function automatic void clear_line_state();
      line_pos    = 0;
      hdr_ok      = 1'b0;
      field_idx   = '0;
      in_field    = 1'b0;
      num_stopped = 1'b0;
      point_seen  = 1'b0;
      frac_cnt    = '0;
      lat_acc     = '0;
      lon_acc     = '0;
      fix_nz      = 1'b0;
      fix_neg     = 1'b0;
      text_ended  = 1'b0;
   endfunction

   // end of a token: pad missing fraction digits with zeros
   function automatic void close_field();
      for (int unsigned k = frac_cnt; k < FRACTION_DIGITS; k++) begin
         if (field_idx == nggp_pkg::TOKEN_LAT) lat_acc = times_ten_plus(lat_acc, 4'd0);
         if (field_idx == nggp_pkg::TOKEN_LON) lon_acc = times_ten_plus(lon_acc, 4'd0);
      end
      if (field_idx < nggp_pkg::TOKEN_MAX) field_idx++;
      in_field = 1'b0;
   endfunction

   function automatic void feed_field_byte(input logic [7:0] c, input logic first);
      logic          is_digit;
      logic [3:0]    d;
      logic [VW-1:0] acc;
      is_digit = (c >= nggp_pkg::CHAR_ZERO) && (c <= nggp_pkg::CHAR_NINE);
      d = is_digit ? 4'(c - nggp_pkg::CHAR_ZERO) : 4'd0;
      if (num_stopped) return;
      if (field_idx == nggp_pkg::TOKEN_LAT || field_idx == nggp_pkg::TOKEN_LON) begin
         acc = (field_idx == nggp_pkg::TOKEN_LAT) ? lat_acc : lon_acc;
         if (is_digit) begin
            if (!point_seen) begin
               acc = times_ten_plus(acc, d);
            end else if (frac_cnt < FRACTION_DIGITS) begin
               acc = times_ten_plus(acc, d);
               frac_cnt++;
            end
         end else if (c == nggp_pkg::CHAR_DOT && !point_seen) begin
            point_seen = 1'b1;
         end else begin
            num_stopped = 1'b1;
         end
         if (field_idx == nggp_pkg::TOKEN_LAT) lat_acc = acc;
         else lon_acc = acc;
      end else if (field_idx == nggp_pkg::TOKEN_FIX) begin
         // fix quality: optional sign, any nonzero digit makes it positive
         if (is_digit) begin
            if (d != 4'd0) fix_nz = 1'b1;
         end else if (first && c == nggp_pkg::CHAR_MINUS) begin
            fix_neg = 1'b1;
         end else if (!(first && c == nggp_pkg::CHAR_PLUS)) begin
            num_stopped = 1'b1;
         end
      end
   endfunction

   // commas split tokens; empty fields collapse
   function automatic void take_text_byte(input logic [7:0] c);
      if (c == nggp_pkg::CHAR_COMMA) begin
         if (in_field) close_field();
         return;
      end
      if (!in_field) begin
         in_field    = 1'b1;
         num_stopped = 1'b0;
         point_seen  = 1'b0;
         frac_cnt    = '0;
         feed_field_byte(c, 1'b1);
      end else begin
         feed_field_byte(c, 1'b0);
      end
   endfunction

   // advance the line state by one byte; a newline queues a summary
   function automatic void predict_byte(input logic [7:0] c);
      line_summary_type s;
      if (c == nggp_pkg::CHAR_DOLLAR) clear_line_state();
      if (line_pos < BUFFER_BYTES - 1) begin
         if (line_pos == 0)
            hdr_ok = (c == GGA_TAG[8*HDR_LEN-1 -: 8]);
         else if (line_pos < HDR_LEN)
            hdr_ok = hdr_ok && (c == GGA_TAG[8*(HDR_LEN-1-line_pos) +: 8]);
         if (!text_ended) begin
            if (c == nggp_pkg::CHAR_NUL) text_ended = 1'b1;
            else take_text_byte(c);
         end
         line_pos++;
      end
      if (c == nggp_pkg::CHAR_NEWLINE) begin
         if (in_field) close_field();
         s.gga = hdr_ok && (line_pos >= HDR_LEN);
         s.fix = s.gga && fix_nz && !fix_neg;
         s.upd = s.fix;
         if (s.upd) begin
            held_lat = lat_acc;
            held_lon = lon_acc;
         end
         s.lat = held_lat;
         s.lon = held_lon;
         summary_q.push_back(s);
         clear_line_state();
      end
   endfunction

   task automatic check_summary();
      line_summary_type e;
      lines_checked++;
      gga_lines    += rsp_sentence_is_gga;
      update_lines += rsp_position_updated;
      if (summary_q.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result item with no line pending: %s=%0b fix=%0b upd=%0b",
                     $time, "gga", rsp_sentence_is_gga, rsp_fix_ok, rsp_position_updated,
                     " lat=%0d lon=%0d", rsp_latitude_micro, rsp_longitude_micro);
         mismatch_count++;
         return;
      end
      e = summary_q.pop_front();
      if (rsp_sentence_is_gga !== e.gga || rsp_fix_ok !== e.fix ||
          rsp_position_updated !== e.upd || rsp_latitude_micro !== e.lat ||
          rsp_longitude_micro !== e.lon) begin
         if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: line %0d mismatch", $time, lines_checked);
            $display("   expected gga=%0b fix=%0b upd=%0b lat=%0d lon=%0d",
                     e.gga, e.fix, e.upd, e.lat, e.lon);
            $display("   actual   gga=%0b fix=%0b upd=%0b lat=%0d lon=%0d",
                     rsp_sentence_is_gga, rsp_fix_ok, rsp_position_updated,
                     rsp_latitude_micro, rsp_longitude_micro);
         end
         mismatch_count++;
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         clear_line_state();
         held_lat = '0;
         held_lon = '0;
         summary_q.delete();
         mismatch_count = 0;
         lines_checked  = 0;
         gga_lines      = 0;
         update_lines   = 0;
      end else begin
         if (req_valid && !req_stall) predict_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) check_summary();
      end
      pending_lines = summary_q.size();
   end

endmodule

[tb/sv/nmea_gga_position_parser_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the GGA parser: clock, reset, byte stimulus, idling and the verdict.
module nmea_gga_position_parser_core_tb;

   localparam int unsigned BUFFER_BYTES    = 100;
   localparam int unsigned FRACTION_DIGITS = 4;
   localparam int unsigned BYTE_TARGET     = 1850;
   localparam int unsigned LINE_TARGET     = 48;
   localparam int unsigned IDLE_LIMIT      = 4000;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_sentence_is_gga;
   logic        rsp_fix_ok;
   logic        rsp_position_updated;
   logic [29:0] rsp_latitude_micro;
   logic [29:0] rsp_longitude_micro;

   int unsigned mismatch_count;
   int unsigned pending_lines;
   int unsigned lines_checked;
   int unsigned gga_lines;
   int unsigned update_lines;

   int unsigned bytes_sent  = 0;
   int unsigned lines_sent  = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;
   bit          no_gaps     = 1'b0;
   bit          stall_quiet = 1'b0;
   logic [7:0]  line_q[$];

   always #1 clock = ~clock;

   nmea_gga_position_parser_core #(
      .BUFFER_BYTES    (BUFFER_BYTES),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sentence_is_gga  (rsp_sentence_is_gga),
      .rsp_fix_ok           (rsp_fix_ok),
      .rsp_position_updated (rsp_position_updated),
      .rsp_latitude_micro   (rsp_latitude_micro),
      .rsp_longitude_micro  (rsp_longitude_micro)
   );

   nmea_gga_position_parser_core_checker #(
      .BUFFER_BYTES    (BUFFER_BYTES),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sentence_is_gga  (rsp_sentence_is_gga),
      .rsp_fix_ok           (rsp_fix_ok),
      .rsp_position_updated (rsp_position_updated),
      .rsp_latitude_micro   (rsp_latitude_micro),
      .rsp_longitude_micro  (rsp_longitude_micro),
      .mismatch_count       (mismatch_count),
      .pending_lines        (pending_lines),
      .lines_checked        (lines_checked),
      .gga_lines            (gga_lines),
      .update_lines         (update_lines)
   );

   // receiver back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin : rsp_stall_gen
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (stall_quiet || pick < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         if (pick < 92) stall_left = $urandom_range(0, 3);
         else if (pick < 98) stall_left = $urandom_range(4, 15);
         else stall_left = $urandom_range(20, 60);
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("nmea_gga_position_parser_core test failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 65) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one byte and hold it until accepted
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_byte(line_q[i]);
      line_q.delete();
      lines_sent++;
   endtask

   // sender holds off until every predicted summary has come back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_lines != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic queue_digits(input int unsigned n);
      repeat (n) line_q.push_back(8'(nggp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
   endtask

   function automatic logic [7:0] junk_char();
      case ($urandom_range(0, 5))
         0:       return nggp_pkg::CHAR_MINUS;
         1:       return nggp_pkg::CHAR_PLUS;
         2:       return 8'h20;
         3:       return 8'h61;
         4:       return nggp_pkg::CHAR_DOT;
         default: return 8'h45;
      endcase
   endfunction

   // ddmm.mmmm style number with occasional junk, long runs and odd fractions
   task automatic queue_number();
      int unsigned n_int;
      if ($urandom_range(0, 11) == 0) line_q.push_back(junk_char());
      case ($urandom_range(0, 15))
         0:       n_int = 0;
         1, 2:    n_int = $urandom_range(6, 12);
         default: n_int = $urandom_range(1, 5);
      endcase
      queue_digits(n_int);
      if ($urandom_range(0, 3) != 0) begin
         line_q.push_back(nggp_pkg::CHAR_DOT);
         queue_digits($urandom_range(0, 7));
      end
      if ($urandom_range(0, 15) == 0) begin
         line_q.push_back(junk_char());
         queue_digits($urandom_range(0, 3));
      end
   endtask

   task automatic queue_fix();
      case ($urandom_range(0, 15))
         0, 1, 2:    queue_text("0");
         3, 4, 5, 6: queue_text("1");
         7, 8:       queue_text("2");
         9:          queue_text("-1");
         10:         queue_text("+6");
         11:         queue_text("00");
         12:         queue_text("07");
         13:         queue_text("-0");
         14:         queue_text("1a");
         default:    queue_text(" 1");
      endcase
   endtask

   function automatic string odd_tag();
      case ($urandom_range(0, 5))
         0:       return "$GPRMC";
         1:       return "$GPGGB";
         2:       return "GPGGA";
         3:       return "$GNGGA";
         4:       return "$GPGG";
         default: return "$";
      endcase
   endfunction

   // GGA-shaped line: random content, empty fields, early cuts, rare NUL
   task automatic build_gga_line(input string tag);
      int unsigned cut;
      string       hex_chars;
      hex_chars = "0123456789ABCDEF";
      cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 8) : 99;
      queue_text(tag);
      for (int unsigned f = 1; f <= 14; f++) begin
         if (f >= cut) break;
         line_q.push_back(nggp_pkg::CHAR_COMMA);
         if ($urandom_range(0, 14) == 0) continue;
         case (f)
            1:       begin queue_digits(6); queue_text(".00"); end
            2, 4:    queue_number();
            3:       queue_text($urandom_range(0, 1) ? "N" : "S");
            5:       queue_text($urandom_range(0, 1) ? "E" : "W");
            6:       queue_fix();
            default: queue_digits($urandom_range(0, 3));
         endcase
      end
      if (cut == 99) begin
         line_q.push_back(8'h2A);
         line_q.push_back(hex_chars[$urandom_range(0, 15)]);
         line_q.push_back(hex_chars[$urandom_range(0, 15)]);
      end
      if ($urandom_range(0, 19) == 0)
         line_q.insert($urandom_range(1, line_q.size()), nggp_pkg::CHAR_NUL);
      line_q.push_back(nggp_pkg::CHAR_NEWLINE);
   endtask

   task automatic build_noise_line();
      repeat ($urandom_range(0, 30)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(nggp_pkg::CHAR_NEWLINE);
   endtask

   // line that runs past the kept byte count
   task automatic build_long_line();
      logic [7:0] b;
      queue_text("$GPGGA,1,");
      queue_number();
      queue_text(",N,");
      queue_number();
      queue_text(",E,");
      queue_fix();
      repeat ($urandom_range(85, 140)) begin
         b = 8'($urandom_range(0, 255));
         line_q.push_back((b == nggp_pkg::CHAR_NEWLINE) ? nggp_pkg::CHAR_COMMA : b);
      end
      line_q.push_back(nggp_pkg::CHAR_NEWLINE);
   endtask

   initial begin : stimulus
      int unsigned pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      queue_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
      send_line();
      queue_text("$GPGGA,123520,4807.038,N,01131.000,E,0,08\n");
      send_line();
      // signs and leading blanks stop lat/lon at zero; negative fix
      queue_text("$GPGGA,1,-12.5,N, 33,E,-1\n");
      send_line();
      // extra fraction digits dropped, missing ones filled, plus sign on fix
      queue_text("$GPGGA,1,12.123456,N,7,E,+2\n");
      send_line();
      // empty fields collapse, saturation, second point stops the number
      queue_text("$GPGGA,,,1,99999999999,S,1.2.3,W,05\n");
      send_line();
      queue_text("$GPGGA,2,3,N,4,E,0a5\n");
      send_line();
      // fix quality absent
      queue_text("$GPGGA,2,3,N,4,E\n");
      send_line();
      // zero byte ends the text of the line
      queue_text("$GPGGA,5,11,N,22,E,3");
      line_q.push_back(nggp_pkg::CHAR_NUL);
      queue_text(",9\n");
      send_line();
      queue_text("$GPRMC,1,2,N,3,E,1\n");
      send_line();
      queue_text("$GPGG\n");
      send_line();
      queue_text("\n");
      send_line();
      // dollar restarts the line
      queue_text("xx$GPGGA,1,4,N,5,E,1\n");
      send_line();
      // bytes beyond the kept count are ignored, newline still ends the line
      queue_text("$GPGGA,1,6,N,7,E,1,");
      repeat (100) line_q.push_back(nggp_pkg::CHAR_NINE);
      line_q.push_back(8'hFF);
      line_q.push_back(8'h80);
      line_q.push_back(nggp_pkg::CHAR_NEWLINE);
      send_line();
      queue_text("GPGGA,1,2,N,3,E,1\n");
      send_line();
      queue_text("$GPGGA,");
      line_q.push_back(8'hFF);
      queue_text(",.5,N,5.,E,-0\n");
      send_line();
      queue_text("$GPGGA1,2,N,3,E,1\n");
      send_line();
      queue_text("$GPGGA,9,0.00005,N,99999.9999,E,1\n");
      send_line();
      wait_all_results();

      // random lines, mostly well formed
      while (bytes_sent < BYTE_TARGET || lines_sent < LINE_TARGET) begin
         no_gaps     = ($urandom_range(0, 5) == 0);
         stall_quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 72) build_gga_line("$GPGGA");
         else if (pick < 82) build_gga_line(odd_tag());
         else if (pick < 94) build_noise_line();
         else build_long_line();
         send_line();
         if ($urandom_range(0, 11) == 0) wait_all_results();
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d lines, incl. directed header, number and fix cases",
               bytes_sent, lines_sent);
      $display("Checked %0d result items: %0d GGA lines, %0d position updates",
               lines_checked, gga_lines, update_lines);
      if (mismatch_count == 0 && pending_lines == 0) begin
         $display("nmea_gga_position_parser_core test passed");
      end else begin
         $display("nmea_gga_position_parser_core test failed");
      end
      $finish;
   end

endmodule
